@@ hw/rtl/dipc_pkg.sv @@
package dipc_pkg;

  localparam int unsigned TimeoutW = 24;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  // Mode as a one-hot state; power_mode carries the 2-bit code
  typedef enum logic [2:0] {
    ModeActive = 3'b001,
    ModeDimmed = 3'b010,
    ModeOff    = 3'b100
  } mode_e;

  typedef enum logic [1:0] {
    ReqTick     = 2'd0,
    ReqActivity = 2'd1,
    ReqWeak     = 2'd2,
    ReqForceOff = 2'd3
  } req_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDimTimeout = 3'd0,
    CfgOffTimeout = 3'd1,
    CfgBrightness = 3'd2,
    CfgDimLevel   = 3'd3,
    CfgKbAutoOn   = 3'd4,
    CfgKbAutoOff  = 3'd5
  } cfg_idx_e;

  localparam logic [1:0] PowerActive = 2'd0;
  localparam logic [1:0] PowerDimmed = 2'd1;
  localparam logic [1:0] PowerOff    = 2'd2;

  localparam logic [TimeoutW-1:0] DimTimeoutRst = 24'd30000;
  localparam logic [TimeoutW-1:0] OffTimeoutRst = 24'd60000;
  localparam logic [7:0]          DimLevelRst   = 8'd20;

  localparam logic [7:0] PwmMin    = 8'd6;
  localparam logic [7:0] PwmMax    = 8'd255;
  localparam logic [6:0] BrightMax = 7'd100;
  // 249 * ceil(2^21 / 99): (p - 1) * 249 / 99 == ((p - 1) * BrightRecip) >> 21 for p <= 99
  localparam int unsigned BrightShift = 21;
  localparam logic [29:0] BrightRecip = 30'd5274816;

  typedef struct packed {
    logic [TimeoutW-1:0] dim_timeout;
    logic [TimeoutW-1:0] off_timeout;
    logic [7:0]          bright_pwm;
    logic [7:0]          dim_level;
    logic                kb_auto_on;
    logic                kb_auto_off;
  } cfg_t;

  typedef struct packed {
    logic [1:0] power_mode;
    logic       mode_changed;
    logic       pwm_write;
    logic [7:0] pwm_duty;
    logic       display_wake;
    logic       display_sleep;
    logic       kb_light_on;
    logic       kb_light_off;
  } res_t;

  function automatic logic [7:0] bright_to_pwm(logic [6:0] pct);
    logic [6:0]  pc;
    logic [29:0] prod;
    logic [7:0]  q;
    pc = (pct == 7'd0) ? 7'd1 : pct;
    prod = 30'(pc - 7'd1) * BrightRecip;
    q = prod[BrightShift +: 8];
    if (pc >= BrightMax) begin
      return PwmMax;
    end
    return PwmMin + q;
  endfunction

endpackage

@@ hw/rtl/dipc_req_if.sv @@
interface dipc_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic       kb_lit_now;

  modport source (output valid, output req_type, output kb_lit_now, input ready);
  modport sink (input valid, input req_type, input kb_lit_now, output ready);
endinterface

@@ hw/rtl/dipc_res_if.sv @@
interface dipc_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] power_mode;
  logic       mode_changed;
  logic       pwm_write;
  logic [7:0] pwm_duty;
  logic       display_wake;
  logic       display_sleep;
  logic       kb_light_on;
  logic       kb_light_off;

  modport source (
    output valid, output power_mode, output mode_changed, output pwm_write,
    output pwm_duty, output display_wake, output display_sleep,
    output kb_light_on, output kb_light_off, input ready
  );
  modport sink (
    input valid, input power_mode, input mode_changed, input pwm_write,
    input pwm_duty, input display_wake, input display_sleep,
    input kb_light_on, input kb_light_off, output ready
  );
endinterface

@@ hw/rtl/dipc_cfg_if.sv @@
interface dipc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [dipc_pkg::CfgIdxW-1:0]  index;
  logic [dipc_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/display_idle_power_controller.sv @@
// Screen power controller: active, dimmed and off, driven by 1 ms ticks and user
// events on the request channel, one result item per request item. Throughput is one
// item per clock while the result channel does not stall; a request is registered,
// evaluated against the mode and idle counter once the result register is free, and
// lands in the result register. A stalled result lets one more request wait in the
// input register before the request channel stalls. Brightness is converted to a PWM
// duty when the register is written, so the per-item path holds only the timeout
// compares and the mode update. Registers are to be written through the config
// channel only while no item is in flight; the block itself does not enforce this.
module display_idle_power_controller #(
  parameter int unsigned IDLE_BITS = 24
) (
  input logic        clk_i,
  input logic        rst_ni,
  dipc_req_if.sink   req_i,
  dipc_res_if.source res_o,
  dipc_cfg_if.sink   cfg_i
);

  dipc_pkg::cfg_t cfg_q, cfg_d;
  logic           cfg_wr;

  logic           s1_valid_q, s1_valid_d;
  logic [1:0]     s1_req_q;
  logic           s1_kb_q;
  logic           out_valid_q, out_valid_d;
  dipc_pkg::res_t out_res_q, step_res;
  logic           accept, advance;

  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid && cfg_i.ready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (cfg_i.index)
        dipc_pkg::CfgDimTimeout: cfg_d.dim_timeout = cfg_i.data;
        dipc_pkg::CfgOffTimeout: cfg_d.off_timeout = cfg_i.data;
        dipc_pkg::CfgBrightness: cfg_d.bright_pwm  = dipc_pkg::bright_to_pwm(cfg_i.data[6:0]);
        dipc_pkg::CfgDimLevel:   cfg_d.dim_level   = cfg_i.data[7:0];
        dipc_pkg::CfgKbAutoOn:   cfg_d.kb_auto_on  = cfg_i.data[0];
        dipc_pkg::CfgKbAutoOff:  cfg_d.kb_auto_off = cfg_i.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dim_timeout <= dipc_pkg::DimTimeoutRst;
      cfg_q.off_timeout <= dipc_pkg::OffTimeoutRst;
      cfg_q.bright_pwm  <= dipc_pkg::PwmMax;
      cfg_q.dim_level   <= dipc_pkg::DimLevelRst;
      cfg_q.kb_auto_on  <= 1'b0;
      cfg_q.kb_auto_off <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // two-entry pipe: input register, then result register
  assign advance     = s1_valid_q && (!out_valid_q || res_o.ready);
  assign req_i.ready = !s1_valid_q || advance;
  assign accept      = req_i.valid && req_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_req_q <= req_i.req_type;
      s1_kb_q  <= req_i.kb_lit_now;
    end
    if (advance) begin
      out_res_q <= step_res;
    end
  end

  dipc_ctrl #(
    .IDLE_BITS(IDLE_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .req_type_i  (s1_req_q),
    .kb_lit_now_i(s1_kb_q),
    .cfg_i       (cfg_q),
    .res_o       (step_res)
  );

  assign res_o.valid         = out_valid_q;
  assign res_o.power_mode    = out_res_q.power_mode;
  assign res_o.mode_changed  = out_res_q.mode_changed;
  assign res_o.pwm_write     = out_res_q.pwm_write;
  assign res_o.pwm_duty      = out_res_q.pwm_duty;
  assign res_o.display_wake  = out_res_q.display_wake;
  assign res_o.display_sleep = out_res_q.display_sleep;
  assign res_o.kb_light_on   = out_res_q.kb_light_on;
  assign res_o.kb_light_off  = out_res_q.kb_light_off;

endmodule

@@ hw/rtl/dipc_ctrl.sv @@
module dipc_ctrl #(
  parameter int unsigned IDLE_BITS = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [1:0]       req_type_i,
  input  logic             kb_lit_now_i,
  input  dipc_pkg::cfg_t   cfg_i,
  output dipc_pkg::res_t   res_o
);

  localparam int unsigned CmpW =
    (IDLE_BITS > dipc_pkg::TimeoutW) ? IDLE_BITS : dipc_pkg::TimeoutW;

  dipc_pkg::mode_e        mode_q, mode_d, target;
  logic [IDLE_BITS-1:0]   idle_q, idle_d, idle_inc;
  logic                   just_woke_q, just_woke_d;
  logic                   kb_was_lit_q, kb_was_lit_d;
  logic                   off_hit, dim_hit;

  always_comb begin
    idle_inc = (&idle_q) ? idle_q : idle_q + 1'b1;
    off_hit = (cfg_i.off_timeout != '0) &&
              (CmpW'(idle_inc) >= CmpW'(cfg_i.off_timeout));
    dim_hit = (cfg_i.dim_timeout != '0) &&
              (CmpW'(idle_inc) >= CmpW'(cfg_i.dim_timeout));

    target      = mode_q;
    idle_d      = idle_q;
    just_woke_d = just_woke_q;

    unique case (dipc_pkg::req_e'(req_type_i))
      dipc_pkg::ReqTick: begin
        idle_d      = idle_inc;
        just_woke_d = 1'b0;
        if (mode_q == dipc_pkg::ModeActive) begin
          if (off_hit) begin
            target = dipc_pkg::ModeOff;
          end else if (dim_hit) begin
            target = dipc_pkg::ModeDimmed;
          end
        end else if (mode_q == dipc_pkg::ModeDimmed && off_hit) begin
          target = dipc_pkg::ModeOff;
        end
      end
      dipc_pkg::ReqActivity: begin
        idle_d = '0;
        if (mode_q == dipc_pkg::ModeOff) begin
          just_woke_d = 1'b1;
        end
        target = dipc_pkg::ModeActive;
      end
      dipc_pkg::ReqWeak: begin
        idle_d = '0;
        if (mode_q == dipc_pkg::ModeDimmed) begin
          target = dipc_pkg::ModeActive;
        end
      end
      dipc_pkg::ReqForceOff: begin
        // a force-off right after waking from off is swallowed once
        if (just_woke_q) begin
          just_woke_d = 1'b0;
        end else begin
          target = dipc_pkg::ModeOff;
        end
      end
    endcase
  end

  always_comb begin
    res_o        = '0;
    mode_d       = target;
    kb_was_lit_d = kb_was_lit_q;

    if (target != mode_q) begin
      res_o.mode_changed = 1'b1;
      unique case (target)
        dipc_pkg::ModeActive: begin
          res_o.pwm_write    = 1'b1;
          res_o.pwm_duty     = cfg_i.bright_pwm;
          res_o.display_wake = (mode_q == dipc_pkg::ModeOff);
          res_o.kb_light_on  = cfg_i.kb_auto_on ||
                               ((mode_q == dipc_pkg::ModeOff) && kb_was_lit_q);
        end
        dipc_pkg::ModeDimmed: begin
          res_o.pwm_write    = 1'b1;
          res_o.pwm_duty     = cfg_i.dim_level;
          res_o.kb_light_off = cfg_i.kb_auto_off;
        end
        dipc_pkg::ModeOff: begin
          res_o.display_sleep = 1'b1;
          res_o.kb_light_off  = 1'b1;
          kb_was_lit_d        = kb_lit_now_i;
        end
        default: ;
      endcase
    end

    unique case (target)
      dipc_pkg::ModeActive: res_o.power_mode = dipc_pkg::PowerActive;
      dipc_pkg::ModeDimmed: res_o.power_mode = dipc_pkg::PowerDimmed;
      dipc_pkg::ModeOff:    res_o.power_mode = dipc_pkg::PowerOff;
      default:              res_o.power_mode = dipc_pkg::PowerActive;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= dipc_pkg::ModeActive;
      idle_q       <= '0;
      just_woke_q  <= 1'b0;
      kb_was_lit_q <= 1'b0;
    end else if (step_i) begin
      mode_q       <= mode_d;
      idle_q       <= idle_d;
      just_woke_q  <= just_woke_d;
      kb_was_lit_q <= kb_was_lit_d;
    end
  end

endmodule

@@ hw/rtl/dipc_chk.sv @@
module dipc_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       valid_i,
  input logic       ready_i,
  input logic [1:0] power_mode_i,
  input logic       mode_changed_i,
  input logic       pwm_write_i,
  input logic [7:0] pwm_duty_i,
  input logic       display_wake_i,
  input logic       display_sleep_i,
  input logic       kb_light_on_i,
  input logic       kb_light_off_i
);

  // no commands without a transition
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !mode_changed_i |-> !pwm_write_i && !display_wake_i && !display_sleep_i &&
                                   !kb_light_on_i && !kb_light_off_i)
    else $error("command issued without a mode change");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !pwm_write_i |-> pwm_duty_i == 8'd0)
    else $error("pwm duty set without pwm write");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && display_wake_i |-> pwm_write_i && power_mode_i == dipc_pkg::PowerActive)
    else $error("wake without active brightness write");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && display_sleep_i |->
      power_mode_i == dipc_pkg::PowerOff && !pwm_write_i && kb_light_off_i)
    else $error("sleep item inconsistent");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(power_mode_i) && $stable(pwm_duty_i) &&
                            $stable(mode_changed_i))
    else $error("stalled result changed");

endmodule

bind display_idle_power_controller dipc_chk u_dipc_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .valid_i        (res_o.valid),
  .ready_i        (res_o.ready),
  .power_mode_i   (res_o.power_mode),
  .mode_changed_i (res_o.mode_changed),
  .pwm_write_i    (res_o.pwm_write),
  .pwm_duty_i     (res_o.pwm_duty),
  .display_wake_i (res_o.display_wake),
  .display_sleep_i(res_o.display_sleep),
  .kb_light_on_i  (res_o.kb_light_on),
  .kb_light_off_i (res_o.kb_light_off)
);

@@ sim/dipc_power_checker.sv @@
`timescale 1ns / 1ps
module dipc_power_checker #(
  parameter int unsigned IDLE_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dipc_req_if         req_mon,
  dipc_res_if         res_mon,
  dipc_cfg_if         cfg_mon,
  output int unsigned due_count_o,
  output int unsigned mismatch_count_o
);

  localparam longint unsigned IdleMax = (64'd1 << IDLE_BITS) - 64'd1;
  localparam int unsigned PrintCap = 40;

  // configuration copy
  logic [dipc_pkg::TimeoutW-1:0] dim_to;
  logic [dipc_pkg::TimeoutW-1:0] off_to;
  logic [6:0]                    bright_pct;
  logic [7:0]                    dim_lvl;
  logic                          kb_on_cfg;
  logic                          kb_off_cfg;

  // controller state
  logic [1:0]      cur_mode;
  longint unsigned idle_cnt;
  logic            just_woke;
  logic            kb_was_lit;

  dipc_pkg::res_t due_results[$];
  int unsigned    mismatches;

  assign mismatch_count_o = mismatches;

  function automatic logic [7:0] pct_to_duty(logic [6:0] pct);
    int unsigned p;
    p = (pct == 7'd0) ? 1 : pct;
    if (p >= dipc_pkg::BrightMax) begin
      return dipc_pkg::PwmMax;
    end
    // 6..255 spread over 1..100 percent
    return 8'(dipc_pkg::PwmMin + ((p - 1) * 249) / 99);
  endfunction

  function automatic void enter_mode(logic [1:0] tgt, logic kb_now, inout dipc_pkg::res_t r);
    logic [1:0] prev;
    prev = cur_mode;
    if (tgt == prev) begin
      return;
    end
    cur_mode = tgt;
    r.mode_changed = 1'b1;
    case (tgt)
      dipc_pkg::PowerActive: begin
        r.pwm_write = 1'b1;
        r.pwm_duty = pct_to_duty(bright_pct);
        r.display_wake = (prev == dipc_pkg::PowerOff);
        r.kb_light_on = kb_on_cfg || (prev == dipc_pkg::PowerOff && kb_was_lit);
      end
      dipc_pkg::PowerDimmed: begin
        r.pwm_write = 1'b1;
        r.pwm_duty = dim_lvl;
        r.kb_light_off = kb_off_cfg;
      end
      default: begin
        r.display_sleep = 1'b1;
        kb_was_lit = kb_now;
        r.kb_light_off = 1'b1;
      end
    endcase
  endfunction

  function automatic dipc_pkg::res_t power_step(logic [1:0] kind, logic kb_now);
    dipc_pkg::res_t r;
    logic off_hit;
    logic dim_hit;
    r = '0;
    case (kind)
      dipc_pkg::ReqTick: begin
        if (idle_cnt < IdleMax) begin
          idle_cnt++;
        end
        off_hit = (off_to != '0) && (idle_cnt >= longint'(off_to));
        dim_hit = (dim_to != '0) && (idle_cnt >= longint'(dim_to));
        if (cur_mode == dipc_pkg::PowerActive) begin
          if (off_hit) begin
            enter_mode(dipc_pkg::PowerOff, kb_now, r);
          end else if (dim_hit) begin
            enter_mode(dipc_pkg::PowerDimmed, kb_now, r);
          end
        end else if (cur_mode == dipc_pkg::PowerDimmed && off_hit) begin
          enter_mode(dipc_pkg::PowerOff, kb_now, r);
        end
        just_woke = 1'b0;
      end
      dipc_pkg::ReqActivity: begin
        idle_cnt = 0;
        if (cur_mode == dipc_pkg::PowerOff) begin
          just_woke = 1'b1;
        end
        enter_mode(dipc_pkg::PowerActive, kb_now, r);
      end
      dipc_pkg::ReqWeak: begin
        idle_cnt = 0;
        if (cur_mode == dipc_pkg::PowerDimmed) begin
          enter_mode(dipc_pkg::PowerActive, kb_now, r);
        end
      end
      default: begin
        // a force off right after a wake from off is swallowed
        if (just_woke) begin
          just_woke = 1'b0;
        end else begin
          enter_mode(dipc_pkg::PowerOff, kb_now, r);
        end
      end
    endcase
    r.power_mode = cur_mode;
    return r;
  endfunction

  task automatic report(string what, int unsigned got, int unsigned want);
    mismatches++;
    if (mismatches <= PrintCap) begin
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    end
  endtask

  task automatic check_field(string what, logic [7:0] got, logic [7:0] want);
    if (got !== want) begin
      report(what, got, want);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    dipc_pkg::res_t want;
    if (!rst_ni) begin
      dim_to = dipc_pkg::DimTimeoutRst;
      off_to = dipc_pkg::OffTimeoutRst;
      bright_pct = dipc_pkg::BrightMax;
      dim_lvl = dipc_pkg::DimLevelRst;
      kb_on_cfg = 1'b0;
      kb_off_cfg = 1'b0;
      cur_mode = dipc_pkg::PowerActive;
      idle_cnt = 0;
      just_woke = 1'b0;
      kb_was_lit = 1'b0;
      due_results.delete();
      mismatches = 0;
      due_count_o <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          dipc_pkg::CfgDimTimeout: dim_to = cfg_mon.data[dipc_pkg::TimeoutW-1:0];
          dipc_pkg::CfgOffTimeout: off_to = cfg_mon.data[dipc_pkg::TimeoutW-1:0];
          dipc_pkg::CfgBrightness: bright_pct = cfg_mon.data[6:0];
          dipc_pkg::CfgDimLevel:   dim_lvl = cfg_mon.data[7:0];
          dipc_pkg::CfgKbAutoOn:   kb_on_cfg = cfg_mon.data[0];
          dipc_pkg::CfgKbAutoOff:  kb_off_cfg = cfg_mon.data[0];
          default: ;
        endcase
      end
      // results always stem from earlier requests, so compare before predicting
      if (res_mon.valid && res_mon.ready) begin
        if (due_results.size() == 0) begin
          report("result item with nothing pending", 1, 0);
        end else begin
          want = due_results.pop_front();
          check_field("power_mode", res_mon.power_mode, want.power_mode);
          check_field("mode_changed", res_mon.mode_changed, want.mode_changed);
          check_field("pwm_write", res_mon.pwm_write, want.pwm_write);
          check_field("pwm_duty", res_mon.pwm_duty, want.pwm_duty);
          check_field("display_wake", res_mon.display_wake, want.display_wake);
          check_field("display_sleep", res_mon.display_sleep, want.display_sleep);
          check_field("kb_light_on", res_mon.kb_light_on, want.kb_light_on);
          check_field("kb_light_off", res_mon.kb_light_off, want.kb_light_off);
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        due_results.push_back(power_step(req_mon.req_type, req_mon.kb_lit_now));
      end
      due_count_o <= due_results.size();
    end
  end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;

  // narrow counter: timeouts beyond its range are never reached
  localparam int unsigned IdleBits = 16;
  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned RandPhases = 10;
  localparam int unsigned PhaseItems = 115;
  localparam logic [dipc_pkg::CfgIdxW-1:0] CfgUnmapped = 3'd7;

  logic        clk;
  logic        rst_n;
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned quiet_cycles = 0;
  int unsigned due_count;
  int unsigned mismatch_count;

  dipc_req_if req_ch();
  dipc_res_if res_ch();
  dipc_cfg_if cfg_ch();

  display_idle_power_controller #(
    .IDLE_BITS(IdleBits)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_ch),
    .res_o (res_ch),
    .cfg_i (cfg_ch)
  );

  dipc_power_checker #(
    .IDLE_BITS(IdleBits)
  ) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .req_mon         (req_ch),
    .res_mon         (res_ch),
    .cfg_mon         (cfg_ch),
    .due_count_o     (due_count),
    .mismatch_count_o(mismatch_count)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_req(dipc_pkg::req_e kind, logic kb);
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.kb_lit_now <= kb;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // hold requests until every result item is back
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [dipc_pkg::CfgIdxW-1:0] idx,
                           logic [dipc_pkg::CfgDataW-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // unused upper data bits get random junk, the block must ignore them
  task automatic set_config(logic [23:0] dim_ms, logic [23:0] off_ms, logic [6:0] pct,
                            logic [7:0] lvl, logic kb_on, logic kb_off);
    logic [23:0] junk;
    junk = 24'($urandom);
    write_reg(dipc_pkg::CfgDimTimeout, dim_ms);
    write_reg(dipc_pkg::CfgOffTimeout, off_ms);
    write_reg(dipc_pkg::CfgBrightness, {junk[23:7], pct});
    write_reg(dipc_pkg::CfgDimLevel, {junk[23:8], lvl});
    write_reg(dipc_pkg::CfgKbAutoOn, {junk[23:1], kb_on});
    write_reg(dipc_pkg::CfgKbAutoOff, {junk[23:1], kb_off});
  endtask

  function automatic logic [23:0] pick_timeout();
    int unsigned r;
    r = $urandom_range(9);
    case (r)
      0: return 24'd0;
      1: return 24'hFFFFFF;
      2: return 24'($urandom);
      default: return 24'($urandom_range(40, 1));
    endcase
  endfunction

  function automatic dipc_pkg::req_e pick_req();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 62) return dipc_pkg::ReqTick;
    if (r < 78) return dipc_pkg::ReqActivity;
    if (r < 90) return dipc_pkg::ReqWeak;
    return dipc_pkg::ReqForceOff;
  endfunction

  initial begin
    rst_n = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.req_type = dipc_pkg::ReqTick;
    req_ch.kb_lit_now = 1'b0;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = dipc_pkg::CfgDimTimeout;
    cfg_ch.data = '0;
    src_idle_pct = 12;
    snk_idle_pct = 65;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: wake, sleep and the swallowed force off after a wake
    send_req(dipc_pkg::ReqWeak, 1'b0);
    send_req(dipc_pkg::ReqTick, 1'b0);
    send_req(dipc_pkg::ReqForceOff, 1'b1);
    send_req(dipc_pkg::ReqWeak, 1'b0);
    send_req(dipc_pkg::ReqForceOff, 1'b0);
    send_req(dipc_pkg::ReqActivity, 1'b0);
    send_req(dipc_pkg::ReqForceOff, 1'b1);
    send_req(dipc_pkg::ReqForceOff, 1'b0);
    send_req(dipc_pkg::ReqActivity, 1'b1);
    send_req(dipc_pkg::ReqTick, 1'b0);
    send_req(dipc_pkg::ReqForceOff, 1'b1);
    send_req(dipc_pkg::ReqActivity, 1'b0);
    drain_results();

    // short timeouts: active -> dimmed -> off, lowest brightness, top dim level
    set_config(24'd3, 24'd5, 7'd1, 8'd255, 1'b1, 1'b1);
    write_reg(CfgUnmapped, 24'hFFFFFF);
    repeat (3) send_req(dipc_pkg::ReqTick, 1'b1);
    send_req(dipc_pkg::ReqWeak, 1'b0);
    repeat (5) send_req(dipc_pkg::ReqTick, 1'b1);
    send_req(dipc_pkg::ReqActivity, 1'b0);
    drain_results();

    // both timeouts disabled, brightness 0 behaves as 1
    set_config(24'd0, 24'd0, 7'd0, 8'd0, 1'b0, 1'b0);
    repeat (3) send_req(dipc_pkg::ReqTick, 1'b0);
    send_req(dipc_pkg::ReqForceOff, 1'b1);
    send_req(dipc_pkg::ReqActivity, 1'b0);
    drain_results();

    // off timeout shorter than dim: active straight to off; brightness above 100
    set_config(24'd6, 24'd2, 7'd127, 8'd128, 1'b0, 1'b1);
    repeat (3) send_req(dipc_pkg::ReqTick, 1'b0);
    send_req(dipc_pkg::ReqActivity, 1'b0);
    drain_results();

    set_config(24'd2, 24'd0, 7'd99, 8'd1, 1'b1, 1'b0);
    repeat (3) send_req(dipc_pkg::ReqTick, 1'b0);
    send_req(dipc_pkg::ReqWeak, 1'b1);
    drain_results();

    for (int p = 0; p < RandPhases; p++) begin
      if (p < 3) begin
        src_idle_pct = 12;
        snk_idle_pct = 65;
      end else if (p < 6) begin
        src_idle_pct = 65;
        snk_idle_pct = 12;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      set_config(pick_timeout(), pick_timeout(), 7'($urandom_range(127)),
                 8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)));
      for (int i = 0; i < PhaseItems; i++) begin
        if (p == 4 && i == PhaseItems / 2) begin
          drain_results();
        end
        send_req(pick_req(), 1'($urandom_range(1)));
      end
      drain_results();
    end

    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/dipc_pkg.sv
hw/rtl/dipc_req_if.sv
hw/rtl/dipc_res_if.sv
hw/rtl/dipc_cfg_if.sv
hw/rtl/dipc_ctrl.sv
hw/rtl/display_idle_power_controller.sv
hw/rtl/dipc_chk.sv
sim/dipc_power_checker.sv
sim/tb_top.sv
